// File: rtl/core/assert_macros.svh
// Assertion macros shared by the ellipse outline point generator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CHK_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is high.
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

`endif

// File: rtl/core/eopg_pkg.sv
// Shared constants, codes and structs of the ellipse outline point generator.
package eopg_pkg;

   localparam int RADIUS_BITS = 10;
   localparam int COORD_BITS  = 11;
   localparam int MASK_BITS   = 4;
   localparam int OUT_BITS    = COORD_BITS + 2;
   localparam int SQ_BITS     = 2 * RADIUS_BITS + 2;
   localparam int ACC_BITS    = 3 * RADIUS_BITS + 4;
   localparam int ALU_W       = ACC_BITS + 2;
   localparam int MUL_A_BITS  = RADIUS_BITS + 2;
   localparam int MUL_B_BITS  = SQ_BITS + 1;

   typedef enum logic {
      REQ_START = 1'b0,
      REQ_NEXT  = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_ONE  = 2'd1,
      PH_TWO  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL
   } alu_op_type;

   // Operand sources. MAIN is the axis that steps every iteration (y in region one,
   // x in region two), SIDE the axis that steps only on a midpoint decision.
   typedef enum logic [3:0] {
      SRC_ZERO,
      SRC_ERR,
      SRC_ERR2,
      SRC_CH_MAIN,
      SRC_CH_SIDE,
      SRC_ST_MAIN,
      SRC_ST_SIDE,
      SRC_K_MAIN,
      SRC_K_SIDE,
      SRC_HALF_K_MAIN,
      SRC_HALF_K_SIDE,
      SRC_RS,
      SRC_RM,
      SRC_TWO_RS,
      SRC_TWO_RM,
      SRC_ONE_M_TWO_RS
   } src_type;

   typedef enum logic [2:0] {
      DST_NONE,
      DST_ERR,
      DST_CH_MAIN,
      DST_CH_SIDE,
      DST_ST_MAIN,
      DST_ST_SIDE,
      DST_K_MAIN,
      DST_K_SIDE
   } dst_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_K_MAIN,
      ST_K_SIDE,
      ST_CH_MAIN_INIT,
      ST_CH_SIDE_INIT,
      ST_ST_SIDE_INIT,
      ST_MAIN_STOP,
      ST_MAIN_ERR,
      ST_MAIN_CH,
      ST_SIDE_TEST,
      ST_SIDE_STOP,
      ST_SIDE_ERR,
      ST_SIDE_CH,
      ST_END_TEST,
      ST_EMIT
   } seq_state_type;

   typedef struct packed {
      logic       load;
      logic       swap;
      logic       init;
      logic       main_inc;
      logic       side_dec;
      alu_op_type op;
      src_type    src_a;
      src_type    src_b;
      dst_type    dst;
   } dp_ctrl_type;

   typedef struct packed {
      logic positive;
      logic non_negative;
      logic radii_zero;
   } dp_stat_type;

   typedef struct packed {
      logic [COORD_BITS-1:0]  center_x;
      logic [COORD_BITS-1:0]  center_y;
      logic [RADIUS_BITS-1:0] offset_x;
      logic [RADIUS_BITS-1:0] offset_y;
      logic [MASK_BITS-1:0]   mask;
   } point_type;

   typedef struct packed {
      logic load;
      logic done;
   } emit_type;

endpackage

// File: rtl/core/eopg_alu.sv
// Shared add, subtract and multiply unit of the ellipse point generator.
module eopg_alu (
   input  eopg_pkg::alu_op_type         op,
   input  logic [eopg_pkg::ALU_W-1:0]   a,
   input  logic [eopg_pkg::ALU_W-1:0]   b,
   output logic [eopg_pkg::ALU_W-1:0]   res
);
   import eopg_pkg::*;

   logic signed [MUL_A_BITS+MUL_B_BITS-1:0] prod;

   // The multiplier sees only the narrow low part of each operand, as signed values.
   assign prod = signed'(a[MUL_A_BITS-1:0]) * signed'(b[MUL_B_BITS-1:0]);

   always_comb begin
      unique case (op)
         ALU_ADD: res = a + b;
         ALU_SUB: res = a - b;
         ALU_MUL: res = {{(ALU_W-MUL_A_BITS-MUL_B_BITS){prod[MUL_A_BITS+MUL_B_BITS-1]}},
                         prod};
         default: res = a + b;
      endcase
   end

endmodule

// File: rtl/core/eopg_dp.sv
// Datapath of the ellipse point generator: held request, recurrence registers, operand muxes.
module eopg_dp (
   input  logic                              clock,
   input  eopg_pkg::dp_ctrl_type             ctrl,
   input  logic [eopg_pkg::COORD_BITS-1:0]   req_center_x,
   input  logic [eopg_pkg::COORD_BITS-1:0]   req_center_y,
   input  logic [eopg_pkg::RADIUS_BITS-1:0]  req_radius_x,
   input  logic [eopg_pkg::RADIUS_BITS-1:0]  req_radius_y,
   input  logic [eopg_pkg::MASK_BITS-1:0]    req_quadrant_mask,
   output eopg_pkg::dp_stat_type             stat,
   output eopg_pkg::point_type               point
);
   import eopg_pkg::*;

   logic [COORD_BITS-1:0]  center_x_ff, center_x_in, center_y_ff, center_y_in;
   logic [RADIUS_BITS-1:0] radius_x_ff, radius_x_in, radius_y_ff, radius_y_in;
   logic [MASK_BITS-1:0]   mask_ff, mask_in;
   logic [RADIUS_BITS-1:0] offset_x_ff, offset_x_in, offset_y_ff, offset_y_in;
   logic [ACC_BITS-1:0]    change_x_ff, change_x_in, change_y_ff, change_y_in;
   logic [ACC_BITS-1:0]    error_ff, error_in;
   logic [ACC_BITS-1:0]    stop_x_ff, stop_x_in, stop_y_ff, stop_y_in;
   logic [SQ_BITS-1:0]     t2rx_ff, t2rx_in, t2ry_ff, t2ry_in;

   logic [ALU_W-1:0]       opa, opb, res;
   logic [ACC_BITS-1:0]    ch_main, ch_side, st_main, st_side;
   logic [SQ_BITS-1:0]     k_main, k_side;
   logic [RADIUS_BITS-1:0] rs, rm;
   logic                   x_ch_wr, y_ch_wr, x_st_wr, y_st_wr, x_k_wr, y_k_wr;

   // In region two the roles of the axes swap.
   assign ch_main = ctrl.swap ? change_x_ff : change_y_ff;
   assign ch_side = ctrl.swap ? change_y_ff : change_x_ff;
   assign st_main = ctrl.swap ? stop_x_ff   : stop_y_ff;
   assign st_side = ctrl.swap ? stop_y_ff   : stop_x_ff;
   assign k_main  = ctrl.swap ? t2ry_ff     : t2rx_ff;
   assign k_side  = ctrl.swap ? t2rx_ff     : t2ry_ff;
   assign rs      = ctrl.swap ? radius_y_ff : radius_x_ff;
   assign rm      = ctrl.swap ? radius_x_ff : radius_y_ff;

   function automatic logic [ALU_W-1:0] pick(input src_type sel);
      logic [ALU_W-1:0] v;
      unique case (sel)
         SRC_ZERO:         v = '0;
         SRC_ERR:          v = {{(ALU_W-ACC_BITS){error_ff[ACC_BITS-1]}}, error_ff};
         SRC_ERR2:         v = {{(ALU_W-ACC_BITS-1){error_ff[ACC_BITS-1]}}, error_ff, 1'b0};
         SRC_CH_MAIN:      v = {{(ALU_W-ACC_BITS){ch_main[ACC_BITS-1]}}, ch_main};
         SRC_CH_SIDE:      v = {{(ALU_W-ACC_BITS){ch_side[ACC_BITS-1]}}, ch_side};
         SRC_ST_MAIN:      v = {{(ALU_W-ACC_BITS){st_main[ACC_BITS-1]}}, st_main};
         SRC_ST_SIDE:      v = {{(ALU_W-ACC_BITS){st_side[ACC_BITS-1]}}, st_side};
         SRC_K_MAIN:       v = ALU_W'(k_main);
         SRC_K_SIDE:       v = ALU_W'(k_side);
         SRC_HALF_K_MAIN:  v = ALU_W'(k_main >> 1);
         SRC_HALF_K_SIDE:  v = ALU_W'(k_side >> 1);
         SRC_RS:           v = ALU_W'(rs);
         SRC_RM:           v = ALU_W'(rm);
         SRC_TWO_RS:       v = ALU_W'(rs) << 1;
         SRC_TWO_RM:       v = ALU_W'(rm) << 1;
         SRC_ONE_M_TWO_RS: v = ALU_W'(1) - (ALU_W'(rs) << 1);
         default:          v = '0;
      endcase
      return v;
   endfunction

   always_comb begin
      opa = pick(ctrl.src_a);
      opb = pick(ctrl.src_b);
   end

   eopg_alu u_alu (
      .op  (ctrl.op),
      .a   (opa),
      .b   (opb),
      .res (res)
   );

   assign x_ch_wr = (ctrl.dst == DST_CH_SIDE && !ctrl.swap) ||
                    (ctrl.dst == DST_CH_MAIN && ctrl.swap);
   assign y_ch_wr = (ctrl.dst == DST_CH_MAIN && !ctrl.swap) ||
                    (ctrl.dst == DST_CH_SIDE && ctrl.swap);
   assign x_st_wr = (ctrl.dst == DST_ST_SIDE && !ctrl.swap) ||
                    (ctrl.dst == DST_ST_MAIN && ctrl.swap);
   assign y_st_wr = (ctrl.dst == DST_ST_MAIN && !ctrl.swap) ||
                    (ctrl.dst == DST_ST_SIDE && ctrl.swap);
   assign x_k_wr  = (ctrl.dst == DST_K_MAIN && !ctrl.swap) ||
                    (ctrl.dst == DST_K_SIDE && ctrl.swap);
   assign y_k_wr  = (ctrl.dst == DST_K_SIDE && !ctrl.swap) ||
                    (ctrl.dst == DST_K_MAIN && ctrl.swap);

   always_comb begin
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      radius_x_in = radius_x_ff;
      radius_y_in = radius_y_ff;
      mask_in     = mask_ff;
      offset_x_in = offset_x_ff;
      offset_y_in = offset_y_ff;
      change_x_in = x_ch_wr ? res[ACC_BITS-1:0] : change_x_ff;
      change_y_in = y_ch_wr ? res[ACC_BITS-1:0] : change_y_ff;
      stop_x_in   = x_st_wr ? res[ACC_BITS-1:0] : stop_x_ff;
      stop_y_in   = y_st_wr ? res[ACC_BITS-1:0] : stop_y_ff;
      t2rx_in     = x_k_wr ? res[SQ_BITS-1:0] : t2rx_ff;
      t2ry_in     = y_k_wr ? res[SQ_BITS-1:0] : t2ry_ff;
      error_in    = (ctrl.dst == DST_ERR) ? res[ACC_BITS-1:0] : error_ff;

      if (ctrl.load) begin
         center_x_in = req_center_x;
         center_y_in = req_center_y;
         radius_x_in = req_radius_x;
         radius_y_in = req_radius_y;
         mask_in     = req_quadrant_mask;
      end

      // Region start: side offset at its radius, main offset, error and main stop at zero.
      if (ctrl.init) begin
         error_in = '0;
         if (ctrl.swap) begin
            stop_x_in   = '0;
            offset_x_in = '0;
            offset_y_in = radius_y_ff;
         end else begin
            stop_y_in   = '0;
            offset_x_in = radius_x_ff;
            offset_y_in = '0;
         end
      end

      if (ctrl.main_inc) begin
         if (ctrl.swap) begin
            offset_x_in = offset_x_ff + RADIUS_BITS'(1);
         end else begin
            offset_y_in = offset_y_ff + RADIUS_BITS'(1);
         end
      end

      if (ctrl.side_dec) begin
         if (ctrl.swap) begin
            offset_y_in = offset_y_ff - RADIUS_BITS'(1);
         end else begin
            offset_x_in = offset_x_ff - RADIUS_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      center_x_ff <= center_x_in;
      center_y_ff <= center_y_in;
      radius_x_ff <= radius_x_in;
      radius_y_ff <= radius_y_in;
      mask_ff     <= mask_in;
      offset_x_ff <= offset_x_in;
      offset_y_ff <= offset_y_in;
      change_x_ff <= change_x_in;
      change_y_ff <= change_y_in;
      error_ff    <= error_in;
      stop_x_ff   <= stop_x_in;
      stop_y_ff   <= stop_y_in;
      t2rx_ff     <= t2rx_in;
      t2ry_ff     <= t2ry_in;
   end

   assign stat.positive     = !res[ALU_W-1] && (res != '0);
   assign stat.non_negative = !res[ALU_W-1];
   assign stat.radii_zero   = (radius_x_ff == '0) && (radius_y_ff == '0);

   assign point.center_x = center_x_ff;
   assign point.center_y = center_y_ff;
   assign point.offset_x = offset_x_ff;
   assign point.offset_y = offset_y_ff;
   assign point.mask     = mask_ff;

endmodule

// File: rtl/core/eopg_seq.sv
// Sequencer that steps the shared unit through precompute, region steps and result hand-off.
`include "assert_macros.svh"

module eopg_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_accept,
   input  logic                   req_type,
   input  eopg_pkg::dp_stat_type  stat,
   input  logic                   out_free,
   output eopg_pkg::dp_ctrl_type  ctrl,
   output eopg_pkg::emit_type     emit,
   output logic                   busy
);
   import eopg_pkg::*;

   seq_state_type state_ff, state_in;
   phase_type     phase_ff, phase_in;
   logic          done_ff, done_in;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      done_in  = done_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_type == REQ_START) begin
                  phase_in = PH_ONE;
                  state_in = ST_K_MAIN;
               end else if (phase_ff == PH_ONE || phase_ff == PH_TWO) begin
                  state_in = ST_MAIN_STOP;
               end else begin
                  phase_in = PH_IDLE;
                  done_in  = 1'b1;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_K_MAIN:       state_in = ST_K_SIDE;
         ST_K_SIDE:       state_in = ST_CH_MAIN_INIT;
         ST_CH_MAIN_INIT: state_in = ST_CH_SIDE_INIT;
         ST_CH_SIDE_INIT: state_in = ST_ST_SIDE_INIT;
         ST_ST_SIDE_INIT: begin
            // With both radii zero the center is shown once and the run ends.
            if (stat.radii_zero) begin
               phase_in = PH_IDLE;
            end
            done_in  = 1'b0;
            state_in = ST_EMIT;
         end
         ST_MAIN_STOP:    state_in = ST_MAIN_ERR;
         ST_MAIN_ERR:     state_in = ST_MAIN_CH;
         ST_MAIN_CH:      state_in = ST_SIDE_TEST;
         ST_SIDE_TEST:    state_in = stat.positive ? ST_SIDE_STOP : ST_END_TEST;
         ST_SIDE_STOP:    state_in = ST_SIDE_ERR;
         ST_SIDE_ERR:     state_in = ST_SIDE_CH;
         ST_SIDE_CH:      state_in = ST_END_TEST;
         ST_END_TEST: begin
            if (stat.non_negative) begin
               done_in  = 1'b0;
               state_in = ST_EMIT;
            end else if (phase_ff == PH_ONE) begin
               phase_in = PH_TWO;
               state_in = ST_CH_MAIN_INIT;
            end else begin
               phase_in = PH_IDLE;
               done_in  = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:         state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl.load     = req_accept && (req_type == REQ_START);
      ctrl.swap     = (phase_ff == PH_TWO);
      ctrl.init     = 1'b0;
      ctrl.main_inc = 1'b0;
      ctrl.side_dec = 1'b0;
      ctrl.op       = ALU_ADD;
      ctrl.src_a    = SRC_ZERO;
      ctrl.src_b    = SRC_ZERO;
      ctrl.dst      = DST_NONE;
      unique case (state_ff)
         ST_K_MAIN: begin
            ctrl.op    = ALU_MUL;
            ctrl.src_a = SRC_TWO_RS;
            ctrl.src_b = SRC_RS;
            ctrl.dst   = DST_K_MAIN;
         end
         ST_K_SIDE: begin
            ctrl.op    = ALU_MUL;
            ctrl.src_a = SRC_TWO_RM;
            ctrl.src_b = SRC_RM;
            ctrl.dst   = DST_K_SIDE;
         end
         ST_CH_MAIN_INIT: begin
            ctrl.init  = 1'b1;
            ctrl.src_a = SRC_HALF_K_MAIN;
            ctrl.dst   = DST_CH_MAIN;
         end
         ST_CH_SIDE_INIT: begin
            ctrl.op    = ALU_MUL;
            ctrl.src_a = SRC_ONE_M_TWO_RS;
            ctrl.src_b = SRC_HALF_K_SIDE;
            ctrl.dst   = DST_CH_SIDE;
         end
         ST_ST_SIDE_INIT: begin
            ctrl.op    = ALU_MUL;
            ctrl.src_a = SRC_RS;
            ctrl.src_b = SRC_K_SIDE;
            ctrl.dst   = DST_ST_SIDE;
         end
         ST_MAIN_STOP: begin
            ctrl.main_inc = 1'b1;
            ctrl.src_a    = SRC_ST_MAIN;
            ctrl.src_b    = SRC_K_MAIN;
            ctrl.dst      = DST_ST_MAIN;
         end
         ST_MAIN_ERR: begin
            ctrl.src_a = SRC_ERR;
            ctrl.src_b = SRC_CH_MAIN;
            ctrl.dst   = DST_ERR;
         end
         ST_MAIN_CH: begin
            ctrl.src_a = SRC_CH_MAIN;
            ctrl.src_b = SRC_K_MAIN;
            ctrl.dst   = DST_CH_MAIN;
         end
         ST_SIDE_TEST: begin
            ctrl.src_a = SRC_ERR2;
            ctrl.src_b = SRC_CH_SIDE;
         end
         ST_SIDE_STOP: begin
            ctrl.side_dec = 1'b1;
            ctrl.op       = ALU_SUB;
            ctrl.src_a    = SRC_ST_SIDE;
            ctrl.src_b    = SRC_K_SIDE;
            ctrl.dst      = DST_ST_SIDE;
         end
         ST_SIDE_ERR: begin
            ctrl.src_a = SRC_ERR;
            ctrl.src_b = SRC_CH_SIDE;
            ctrl.dst   = DST_ERR;
         end
         ST_SIDE_CH: begin
            ctrl.src_a = SRC_CH_SIDE;
            ctrl.src_b = SRC_K_SIDE;
            ctrl.dst   = DST_CH_SIDE;
         end
         ST_END_TEST: begin
            ctrl.op    = ALU_SUB;
            ctrl.src_a = SRC_ST_SIDE;
            ctrl.src_b = SRC_ST_MAIN;
         end
         default: begin
         end
      endcase
   end

   assign emit.load = (state_ff == ST_EMIT) && out_free;
   assign emit.done = done_ff;
   assign busy      = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   `CHK_IMPLIES(a_step_needs_region, clock, reset, state_ff == ST_MAIN_STOP,
      phase_ff == PH_ONE || phase_ff == PH_TWO)
   `CHK_NEXT(a_emit_returns_idle, clock, reset, emit.load, state_ff == ST_IDLE)

endmodule

// File: rtl/core/ellipse_outline_point_generator_core.sv
// Top level of the ellipse outline point generator: handshakes, sequencer, datapath, result register.
// A start word runs the precompute and region-start steps; a next word runs the main-axis steps,
// then the side-axis steps if the midpoint test is positive, and a region-two start when it
// crosses into region two; a next word while idle yields the done result. Every step uses the
// single shared add/multiply unit, one operation per cycle; requests stall until a result is loaded.
// Synchronous active-high reset empties the result register and leaves the block idle.
`include "assert_macros.svh"

module ellipse_outline_point_generator_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_type,
   input  logic [eopg_pkg::COORD_BITS-1:0]       req_center_x,
   input  logic [eopg_pkg::COORD_BITS-1:0]       req_center_y,
   input  logic [eopg_pkg::RADIUS_BITS-1:0]      req_radius_x,
   input  logic [eopg_pkg::RADIUS_BITS-1:0]      req_radius_y,
   input  logic [eopg_pkg::MASK_BITS-1:0]        req_quadrant_mask,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [eopg_pkg::OUT_BITS-1:0]  rsp_upper_right_x,
   output logic signed [eopg_pkg::OUT_BITS-1:0]  rsp_upper_right_y,
   output logic signed [eopg_pkg::OUT_BITS-1:0]  rsp_upper_left_x,
   output logic signed [eopg_pkg::OUT_BITS-1:0]  rsp_upper_left_y,
   output logic signed [eopg_pkg::OUT_BITS-1:0]  rsp_lower_right_x,
   output logic signed [eopg_pkg::OUT_BITS-1:0]  rsp_lower_right_y,
   output logic signed [eopg_pkg::OUT_BITS-1:0]  rsp_lower_left_x,
   output logic signed [eopg_pkg::OUT_BITS-1:0]  rsp_lower_left_y,
   output logic [eopg_pkg::MASK_BITS-1:0]        rsp_pixel_enables,
   output logic                                  rsp_point_valid,
   output logic                                  rsp_done_res
);
   import eopg_pkg::*;

   dp_ctrl_type ctrl;
   dp_stat_type stat;
   point_type   point;
   emit_type    emit;
   logic        busy, req_accept, out_free;

   logic                rsp_valid_ff;
   logic [OUT_BITS-1:0] ur_x_ff, ur_y_ff, ul_x_ff, ul_y_ff;
   logic [OUT_BITS-1:0] lr_x_ff, lr_y_ff, ll_x_ff, ll_y_ff;
   logic [MASK_BITS-1:0] enables_ff;
   logic                point_valid_ff, done_res_ff;

   logic [OUT_BITS-1:0] cx, cy, ox, oy, x_plus, x_minus, y_plus, y_minus;

   assign req_stall  = busy;
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   eopg_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_type   (req_type),
      .stat       (stat),
      .out_free   (out_free),
      .ctrl       (ctrl),
      .emit       (emit),
      .busy       (busy)
   );

   eopg_dp u_dp (
      .clock             (clock),
      .ctrl              (ctrl),
      .req_center_x      (req_center_x),
      .req_center_y      (req_center_y),
      .req_radius_x      (req_radius_x),
      .req_radius_y      (req_radius_y),
      .req_quadrant_mask (req_quadrant_mask),
      .stat              (stat),
      .point             (point)
   );

   // Coordinates wrap to the result width.
   assign cx      = OUT_BITS'(point.center_x);
   assign cy      = OUT_BITS'(point.center_y);
   assign ox      = OUT_BITS'(point.offset_x);
   assign oy      = OUT_BITS'(point.offset_y);
   assign x_plus  = cx + ox;
   assign x_minus = cx - ox;
   assign y_plus  = cy + oy;
   assign y_minus = cy - oy;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.load) begin
         if (emit.done) begin
            ur_x_ff        <= '0;
            ur_y_ff        <= '0;
            ul_x_ff        <= '0;
            ul_y_ff        <= '0;
            lr_x_ff        <= '0;
            lr_y_ff        <= '0;
            ll_x_ff        <= '0;
            ll_y_ff        <= '0;
            enables_ff     <= '0;
            point_valid_ff <= 1'b0;
            done_res_ff    <= 1'b1;
         end else begin
            ur_x_ff        <= x_plus;
            ur_y_ff        <= y_minus;
            ul_x_ff        <= x_minus;
            ul_y_ff        <= y_minus;
            lr_x_ff        <= x_plus;
            lr_y_ff        <= y_plus;
            ll_x_ff        <= x_minus;
            ll_y_ff        <= y_plus;
            enables_ff     <= point.mask;
            point_valid_ff <= 1'b1;
            done_res_ff    <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_upper_right_x = ur_x_ff;
   assign rsp_upper_right_y = ur_y_ff;
   assign rsp_upper_left_x  = ul_x_ff;
   assign rsp_upper_left_y  = ul_y_ff;
   assign rsp_lower_right_x = lr_x_ff;
   assign rsp_lower_right_y = lr_y_ff;
   assign rsp_lower_left_x  = ll_x_ff;
   assign rsp_lower_left_y  = ll_y_ff;
   assign rsp_pixel_enables = enables_ff;
   assign rsp_point_valid   = point_valid_ff;
   assign rsp_done_res      = done_res_ff;

   `CHK_NEXT(a_busy_after_accept, clock, reset, req_accept, req_stall)
   `CHK_IMPLIES(a_point_or_done, clock, reset, rsp_valid_ff, point_valid_ff ^ done_res_ff)

endmodule
